### rtl/rv32ie_pkg.sv
// ----------------------------------------------------------------------------
// RV32I execute core package
// Item types, opcodes and codes shared by the core and its checker.
// ----------------------------------------------------------------------------
package rv32ie_pkg;

	typedef struct packed {
		logic        mode;
		logic [31:0] instruction;
		logic [31:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [1:0]  mem_request;
		logic [31:0] mem_address;
		logic [1:0]  mem_size;
		logic [31:0] store_data;
		logic [4:0]  write_index;
		logic [31:0] write_value;
		logic        halted;
		logic        unsupported;
	} out_item_t;

	// Memory request codes
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_STORE = 2'd2;

	// Item modes
	localparam logic MODE_EXEC = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	// Pending load kinds
	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_LB   = 3'd1,
		KIND_LH   = 3'd2,
		KIND_LW   = 3'd3,
		KIND_LBU  = 3'd4,
		KIND_LHU  = 3'd5
	} load_kind_t;

	// Major opcodes
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
	localparam logic [6:0]  F7_ZERO     = 7'h00;
	localparam logic [6:0]  F7_ALT      = 7'h20;

	// Configuration register indexes and reset values
	localparam logic CFG_START_PC  = 1'b0;
	localparam logic CFG_STACK_TOP = 1'b1;
	localparam logic [31:0] START_PC_RST  = 32'h8000_0000;
	localparam logic [31:0] STACK_TOP_RST = 32'h8800_0000;

	localparam logic [4:0] SP_INDEX = 5'd2;

endpackage

### rtl/rv32ie_ram.sv
// ----------------------------------------------------------------------------
// RV32I execute core RAM
// Generic RAM, one write port and two registered read ports with enable.
// ----------------------------------------------------------------------------
module rv32ie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### rtl/rv32i_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// RV32I instruction execute core
// Executes one RV32I instruction or one load return per item.
// ----------------------------------------------------------------------------
// Each item is either an instruction word (mode 0) or the read data for the
// last issued load (mode 1); every item yields exactly one result item. The
// core accepts one item per cycle while in_stall is low. The accepting edge
// loads the input register and reads rs1 and rs2 from the register file RAM
// (registered read); the input stage then decodes and executes, and loads
// the result register once that register is free. A write from the item
// being executed is forwarded to the item accepted in the same cycle, so
// back-to-back dependent instructions run at full rate. The result register
// decouples the output: a stalled result holds the input stage only once
// that stage is also full. Register file
// reset is handled by one valid flop per entry (x2 reads stack_top until
// written), so there is no clearing pass after reset. Loads and stores leave
// as memory requests; a load return writes the pending destination with sign
// or zero extension. EBREAK halts the core, after which every item returns
// the held PC with halted set. Write start_pc and stack_top only while idle;
// each write also reloads the PC or x2 at once.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute_core #(
	parameter int REG_COUNT = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rv32ie_pkg::in_item_t  in_data,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output rv32ie_pkg::out_item_t out_data,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int AW = $clog2(REG_COUNT);
	localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

	// Register index exists and is not x0
	function automatic logic reg_ok(input logic [4:0] idx);
		reg_ok = (idx != 5'd0) && ({1'b0, idx} < REG_LIMIT);
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [31:0] start_pc_q;
	logic [31:0] stack_top_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == rv32ie_pkg::CFG_STACK_TOP) ? stack_top_q : start_pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q  <= rv32ie_pkg::START_PC_RST;
			stack_top_q <= rv32ie_pkg::STACK_TOP_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == rv32ie_pkg::CFG_START_PC) begin
				start_pc_q <= pwdata;
			end else begin
				stack_top_q <= pwdata;
			end
		end
	end

	// ------------------------------------------------------------------
	// Handshake and stage control
	// ------------------------------------------------------------------
	logic valid_s1;
	logic out_valid_q;
	logic s1_adv;
	logic s1_fire;
	logic in_acc;

	assign s1_adv   = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && s1_adv;
	assign in_stall = valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Register file: RAM plus per-entry valid flops
	// ------------------------------------------------------------------
	logic                 rf_we;
	logic [AW-1:0]        rf_waddr;
	logic [4:0]           rf_widx;
	logic [31:0]          rf_wdata;
	logic [31:0]          ram_rd1;
	logic [31:0]          ram_rd2;
	logic [REG_COUNT-1:0] vld_q;
	logic [4:0]           in_rs1;
	logic [4:0]           in_rs2;

	// Execute write-back, or a stack_top write that reloads x2
	logic                 ex_we;
	logic [4:0]           ex_widx;
	logic [31:0]          ex_wval;

	always_comb begin
		if (cfg_wr && paddr[2] == rv32ie_pkg::CFG_STACK_TOP) begin
			rf_we    = 1'b1;
			rf_widx  = rv32ie_pkg::SP_INDEX;
			rf_wdata = pwdata;
		end else begin
			rf_we    = ex_we;
			rf_widx  = ex_widx;
			rf_wdata = ex_wval;
		end
	end

	assign rf_waddr = rf_widx[AW-1:0];
	assign in_rs1   = in_data.instruction[19:15];
	assign in_rs2   = in_data.instruction[24:20];

	rv32ie_ram #(
		.WIDTH (32),
		.DEPTH (REG_COUNT)
	) u_regfile (
		.clk     (clk),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.re      (in_acc),
		.raddr_a (in_rs1[AW-1:0]),
		.raddr_b (in_rs2[AW-1:0]),
		.rdata_a (ram_rd1),
		.rdata_b (ram_rd2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (rf_we) begin
			vld_q[rf_waddr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Input stage: item, entry valid bits and forwarded writes
	// ------------------------------------------------------------------
	rv32ie_pkg::in_item_t item_s1;
	logic        vld1_s1;
	logic        vld2_s1;
	logic        fwd1_s1;
	logic        fwd2_s1;
	logic [31:0] fwdv1_s1;
	logic [31:0] fwdv2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Catch a write landing in the same cycle as the RAM read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1  <= in_data;
			vld1_s1  <= vld_q[in_rs1[AW-1:0]];
			vld2_s1  <= vld_q[in_rs2[AW-1:0]];
			fwd1_s1  <= rf_we && (rf_widx == in_rs1);
			fwd2_s1  <= rf_we && (rf_widx == in_rs2);
			fwdv1_s1 <= rf_wdata;
			fwdv2_s1 <= rf_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Operand resolve
	// ------------------------------------------------------------------
	logic [31:0] ins;
	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [6:0]  f7;
	logic [31:0] a;
	logic [31:0] b;

	assign ins = item_s1.instruction;
	assign opc = ins[6:0];
	assign rd  = ins[11:7];
	assign f3  = ins[14:12];
	assign rs1 = ins[19:15];
	assign rs2 = ins[24:20];
	assign f7  = ins[31:25];

	always_comb begin
		if (!reg_ok(rs1)) begin
			a = '0;
		end else if (fwd1_s1) begin
			a = fwdv1_s1;
		end else if (vld1_s1) begin
			a = ram_rd1;
		end else begin
			a = (rs1 == rv32ie_pkg::SP_INDEX) ? stack_top_q : '0;
		end
	end

	always_comb begin
		if (!reg_ok(rs2)) begin
			b = '0;
		end else if (fwd2_s1) begin
			b = fwdv2_s1;
		end else if (vld2_s1) begin
			b = ram_rd2;
		end else begin
			b = (rs2 == rv32ie_pkg::SP_INDEX) ? stack_top_q : '0;
		end
	end

	// ------------------------------------------------------------------
	// Execute
	// ------------------------------------------------------------------
	logic [31:0]            pc_q;
	logic                   halt_q;
	logic [4:0]             pend_dest_q;
	rv32ie_pkg::load_kind_t pend_kind_q;

	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] pc_plus4;
	logic [31:0] addr_sum;

	logic [31:0]            npc;
	logic                   halt_nx;
	logic [4:0]             pend_dest_nx;
	rv32ie_pkg::load_kind_t pend_kind_nx;
	logic                   wr_req;
	logic [4:0]             wr_idx;
	logic [31:0]            wr_val;
	logic                   uns;
	logic                   take;
	logic [1:0]             req;
	logic [31:0]            maddr;
	logic [1:0]             msize;
	logic [31:0]            sdata;
	logic [31:0]            ld_val;
	rv32ie_pkg::out_item_t  res;

	assign imm_i    = {{20{ins[31]}}, ins[31:20]};
	assign imm_s    = {{20{ins[31]}}, ins[31:25], ins[11:7]};
	assign imm_b    = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign imm_j    = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
	assign pc_plus4 = pc_q + 32'd4;

	// Sign or zero extend the returned load data
	always_comb begin
		case (pend_kind_q)
			rv32ie_pkg::KIND_LB:  ld_val = {{24{item_s1.load_data[7]}}, item_s1.load_data[7:0]};
			rv32ie_pkg::KIND_LH:  ld_val = {{16{item_s1.load_data[15]}}, item_s1.load_data[15:0]};
			rv32ie_pkg::KIND_LBU: ld_val = {24'd0, item_s1.load_data[7:0]};
			rv32ie_pkg::KIND_LHU: ld_val = {16'd0, item_s1.load_data[15:0]};
			default:              ld_val = item_s1.load_data;
		endcase
	end

	always_comb begin
		npc          = pc_plus4;
		halt_nx      = halt_q;
		pend_dest_nx = pend_dest_q;
		pend_kind_nx = pend_kind_q;
		wr_req       = 1'b0;
		wr_idx       = rd;
		wr_val       = '0;
		uns          = 1'b0;
		take         = 1'b0;
		req          = rv32ie_pkg::REQ_NONE;
		maddr        = '0;
		msize        = '0;
		sdata        = '0;
		addr_sum     = a + imm_i;

		if (halt_q) begin
			npc = pc_q;
		end else if (item_s1.mode == rv32ie_pkg::MODE_LOAD) begin
			npc = pc_q;
			if (pend_kind_q != rv32ie_pkg::KIND_NONE) begin
				wr_req       = 1'b1;
				wr_idx       = pend_dest_q;
				wr_val       = ld_val;
				pend_kind_nx = rv32ie_pkg::KIND_NONE;
				pend_dest_nx = '0;
			end
		end else begin
			case (opc)
				rv32ie_pkg::OP_LUI: begin
					wr_req = 1'b1;
					wr_val = {ins[31:12], 12'd0};
				end
				rv32ie_pkg::OP_JAL: begin
					wr_req = 1'b1;
					wr_val = pc_plus4;
					npc    = pc_q + imm_j;
				end
				rv32ie_pkg::OP_JALR: begin
					if (f3 != 3'd0) begin
						uns = 1'b1;
					end else begin
						wr_req = 1'b1;
						wr_val = pc_plus4;
						npc    = {addr_sum[31:1], 1'b0};
					end
				end
				rv32ie_pkg::OP_BRANCH: begin
					case (f3)
						3'd0:    take = (a == b);
						3'd1:    take = (a != b);
						3'd4:    take = ($signed(a) < $signed(b));
						3'd5:    take = !($signed(a) < $signed(b));
						3'd6:    take = (a < b);
						3'd7:    take = (a >= b);
						default: uns  = 1'b1;
					endcase
					if (take) begin
						npc = pc_q + imm_b;
					end
				end
				rv32ie_pkg::OP_LOAD: begin
					if (f3 == 3'd3 || f3 > 3'd5) begin
						uns = 1'b1;
					end else begin
						req          = rv32ie_pkg::REQ_LOAD;
						maddr        = addr_sum;
						msize        = f3[1:0];
						pend_dest_nx = rd;
						case (f3)
							3'd0:    pend_kind_nx = rv32ie_pkg::KIND_LB;
							3'd1:    pend_kind_nx = rv32ie_pkg::KIND_LH;
							3'd4:    pend_kind_nx = rv32ie_pkg::KIND_LBU;
							3'd5:    pend_kind_nx = rv32ie_pkg::KIND_LHU;
							default: pend_kind_nx = rv32ie_pkg::KIND_LW;
						endcase
					end
				end
				rv32ie_pkg::OP_STORE: begin
					if (f3 > 3'd2) begin
						uns = 1'b1;
					end else begin
						req   = rv32ie_pkg::REQ_STORE;
						maddr = a + imm_s;
						msize = f3[1:0];
						sdata = b;
					end
				end
				rv32ie_pkg::OP_IMM: begin
					wr_req = 1'b1;
					case (f3)
						3'd0: wr_val = addr_sum;
						3'd2: wr_val = {31'd0, $signed(a) < $signed(imm_i)};
						3'd3: wr_val = {31'd0, a < imm_i};
						3'd4: wr_val = a ^ imm_i;
						3'd6: wr_val = a | imm_i;
						3'd7: wr_val = a & imm_i;
						3'd1: begin
							if (f7 != rv32ie_pkg::F7_ZERO) begin
								uns = 1'b1;
							end else begin
								wr_val = a << rs2;
							end
						end
						default: begin
							if (f7 == rv32ie_pkg::F7_ZERO) begin
								wr_val = a >> rs2;
							end else if (f7 == rv32ie_pkg::F7_ALT) begin
								wr_val = $signed(a) >>> rs2;
							end else begin
								uns = 1'b1;
							end
						end
					endcase
					if (uns) begin
						wr_req = 1'b0;
						wr_val = '0;
					end
				end
				rv32ie_pkg::OP_SYSTEM: begin
					if (ins == rv32ie_pkg::EBREAK_WORD) begin
						halt_nx = 1'b1;
						npc     = pc_q;
					end else begin
						uns = 1'b1;
					end
				end
				default: uns = 1'b1;
			endcase
		end
	end

	// Drop writes to x0 and to missing registers
	assign ex_we   = s1_fire && wr_req && reg_ok(wr_idx);
	assign ex_widx = wr_idx;
	assign ex_wval = wr_val;

	always_comb begin
		res             = '0;
		res.next_pc     = npc;
		res.mem_request = req;
		res.mem_address = maddr;
		res.mem_size    = msize;
		res.store_data  = sdata;
		res.halted      = halt_nx;
		res.unsupported = uns;
		if (wr_req && reg_ok(wr_idx)) begin
			res.write_index = wr_idx;
			res.write_value = wr_val;
		end
	end

	// ------------------------------------------------------------------
	// Architectural state: advance with each executed item
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= rv32ie_pkg::START_PC_RST;
			halt_q      <= 1'b0;
			pend_dest_q <= '0;
			pend_kind_q <= rv32ie_pkg::KIND_NONE;
		end else if (cfg_wr && paddr[2] == rv32ie_pkg::CFG_START_PC) begin
			pc_q <= pwdata;
		end else if (s1_fire) begin
			pc_q        <= npc;
			halt_q      <= halt_nx;
			pend_dest_q <= pend_dest_nx;
			pend_kind_q <= pend_kind_nx;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_data <= res;
		end
	end

endmodule

### rtl/rv32ie_chk.sv
// ----------------------------------------------------------------------------
// RV32I execute core checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module rv32ie_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input rv32ie_pkg::out_item_t out_data,
	input logic                  out_valid,
	input logic                  out_stall
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Come out of reset with no result
	a_rst_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid straight after reset");

	// A halted core reports nothing but its PC
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.halted |->
			out_data.mem_request == rv32ie_pkg::REQ_NONE &&
			out_data.write_index == 5'd0 && !out_data.unsupported)
		else $error("halted result carries work");

	// No request means no address, size or store data; no write means no value
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(out_data.mem_request != rv32ie_pkg::REQ_NONE ||
			 (out_data.mem_address == 32'd0 && out_data.mem_size == 2'd0)) &&
			(out_data.mem_request == rv32ie_pkg::REQ_STORE ||
			 out_data.store_data == 32'd0) &&
			(out_data.write_index != 5'd0 || out_data.write_value == 32'd0))
		else $error("stray fields in result");

	// Never stall the input while the result side is free
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

endmodule

bind rv32i_instruction_execute_core rv32ie_chk u_rv32ie_chk (.*);

### tb/retire_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Retire scoreboard for the RV32I execute core
// Predicts the result item of every accepted item from a private copy of the
// register file, PC, pending load and halt state, and checks results in order.
// ----------------------------------------------------------------------------
package retire_scoreboard_pkg;

	import rv32ie_pkg::*;

	// funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB   = 3'd0;
	localparam logic [2:0] F3_LH   = 3'd1;
	localparam logic [2:0] F3_LW   = 3'd2;
	localparam logic [2:0] F3_LBU  = 3'd4;
	localparam logic [2:0] F3_LHU  = 3'd5;

	localparam logic [2:0] F3_SB   = 3'd0;
	localparam logic [2:0] F3_SH   = 3'd1;
	localparam logic [2:0] F3_SW   = 3'd2;

	localparam logic [2:0] F3_JALR = 3'd0;

	class retire_scoreboard;
		logic [31:0] gpr [32];
		logic [31:0] pc;
		logic [31:0] cfg_value [2];
		logic [4:0]  load_dest;
		load_kind_t  load_kind;
		logic        halt_seen;
		out_item_t   expected_retires [$];
		int          errors;

		function new();
			foreach (gpr[i]) gpr[i] = '0;
			cfg_value[CFG_START_PC]  = START_PC_RST;
			cfg_value[CFG_STACK_TOP] = STACK_TOP_RST;
			gpr[SP_INDEX] = STACK_TOP_RST;
			pc        = START_PC_RST;
			load_dest = '0;
			load_kind = KIND_NONE;
			halt_seen = 1'b0;
			errors    = 0;
		endfunction

		// A register write takes effect at once: PC or x2 follows it.
		function void apply_config(logic idx, logic [31:0] val);
			cfg_value[idx] = val;
			if (idx == CFG_START_PC)
				pc = val;
			else
				gpr[SP_INDEX] = val;
		endfunction

		function void write_reg(logic [4:0] idx, logic [31:0] val, inout out_item_t r);
			if (idx == '0)
				return;
			gpr[idx]      = val;
			r.write_index = idx;
			r.write_value = val;
		endfunction

		function out_item_t retire(in_item_t it);
			out_item_t   r;
			logic [31:0] ins, a, b, imm_i, nxt, val;
			logic [6:0]  opc, f7;
			logic [4:0]  rd, rs1, rs2;
			logic [2:0]  f3;
			logic        bad, take;
			r = '0;
			if (halt_seen) begin
				r.next_pc = pc;
				r.halted  = 1'b1;
				return r;
			end
			if (it.mode == MODE_LOAD) begin
				if (load_kind != KIND_NONE) begin
					case (load_kind)
						KIND_LB:  val = {{24{it.load_data[7]}}, it.load_data[7:0]};
						KIND_LH:  val = {{16{it.load_data[15]}}, it.load_data[15:0]};
						KIND_LBU: val = {24'd0, it.load_data[7:0]};
						KIND_LHU: val = {16'd0, it.load_data[15:0]};
						default:  val = it.load_data;
					endcase
					write_reg(load_dest, val, r);
					load_kind = KIND_NONE;
					load_dest = '0;
				end
				r.next_pc = pc;
				return r;
			end
			ins   = it.instruction;
			opc   = ins[6:0];
			rd    = ins[11:7];
			f3    = ins[14:12];
			rs1   = ins[19:15];
			rs2   = ins[24:20];
			f7    = ins[31:25];
			a     = gpr[rs1];
			b     = gpr[rs2];
			imm_i = {{20{ins[31]}}, ins[31:20]};
			nxt   = pc + 32'd4;
			val   = '0;
			bad   = 1'b0;
			take  = 1'b0;
			case (opc)
				OP_LUI: write_reg(rd, {ins[31:12], 12'd0}, r);
				OP_JAL: begin
					write_reg(rd, pc + 32'd4, r);
					nxt = pc + {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
				end
				OP_JALR: begin
					if (f3 != F3_JALR) begin
						bad = 1'b1;
					end else begin
						nxt = (a + imm_i) & ~32'd1;
						write_reg(rd, pc + 32'd4, r);
					end
				end
				OP_BRANCH: begin
					case (f3)
						F3_BEQ:  take = (a == b);
						F3_BNE:  take = (a != b);
						F3_BLT:  take = ($signed(a) < $signed(b));
						F3_BGE:  take = ($signed(a) >= $signed(b));
						F3_BLTU: take = (a < b);
						F3_BGEU: take = (a >= b);
						default: bad = 1'b1;
					endcase
					if (take)
						nxt = pc + {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
				end
				OP_LOAD: begin
					case (f3)
						F3_LB:   load_kind = KIND_LB;
						F3_LH:   load_kind = KIND_LH;
						F3_LW:   load_kind = KIND_LW;
						F3_LBU:  load_kind = KIND_LBU;
						F3_LHU:  load_kind = KIND_LHU;
						default: bad = 1'b1;
					endcase
					if (!bad) begin
						r.mem_request = REQ_LOAD;
						r.mem_address = a + imm_i;
						r.mem_size    = f3[1:0];
						load_dest     = rd;
					end
				end
				OP_STORE: begin
					if (f3 > F3_SW) begin
						bad = 1'b1;
					end else begin
						r.mem_request = REQ_STORE;
						r.mem_address = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
						r.mem_size    = f3[1:0];
						r.store_data  = b;
					end
				end
				OP_IMM: begin
					case (f3)
						F3_ADD:  val = a + imm_i;
						F3_SLT:  val = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
						F3_SLTU: val = (a < imm_i) ? 32'd1 : 32'd0;
						F3_XOR:  val = a ^ imm_i;
						F3_OR:   val = a | imm_i;
						F3_AND:  val = a & imm_i;
						F3_SLL: begin
							if (f7 == F7_ZERO)
								val = a << rs2;
							else
								bad = 1'b1;
						end
						default: begin
							if (f7 == F7_ZERO)
								val = a >> rs2;
							else if (f7 == F7_ALT)
								val = $signed(a) >>> rs2;
							else
								bad = 1'b1;
						end
					endcase
					if (!bad)
						write_reg(rd, val, r);
				end
				OP_SYSTEM: begin
					if (ins == EBREAK_WORD) begin
						halt_seen = 1'b1;
						nxt       = pc;
					end else begin
						bad = 1'b1;
					end
				end
				default: bad = 1'b1;
			endcase
			pc            = nxt;
			r.next_pc     = nxt;
			r.halted      = halt_seen;
			r.unsupported = bad;
			return r;
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		function void note_item(in_item_t it);
			expected_retires.push_back(retire(it));
		endfunction

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %h expected %h", name, got, want));
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_retires.size() == 0) begin
				report($sformatf("result item with nothing expected, next_pc %h", got.next_pc));
				return;
			end
			want = expected_retires.pop_front();
			check_field("next_pc", got.next_pc, want.next_pc);
			check_field("mem_request", got.mem_request, want.mem_request);
			check_field("mem_address", got.mem_address, want.mem_address);
			check_field("mem_size", got.mem_size, want.mem_size);
			check_field("store_data", got.store_data, want.store_data);
			check_field("write_index", got.write_index, want.write_index);
			check_field("write_value", got.write_value, want.write_value);
			check_field("halted", got.halted, want.halted);
			check_field("unsupported", got.unsupported, want.unsupported);
		endtask
	endclass

endpackage

### tb/rv32i_instruction_execute_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RV32I instruction execute core testbench
// Drives instruction words and load returns through the item handshake,
// reprograms start_pc and stack_top between phases over the APB port, and
// checks every result item against the retire scoreboard.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute_core_tb;

	import rv32ie_pkg::*;
	import retire_scoreboard_pkg::*;

	// Opcodes the core must flag as unsupported
	localparam logic [6:0] OP_RTYPE = 7'h33;
	localparam logic [6:0] OP_AUIPC = 7'h17;
	localparam logic [6:0] OP_FENCE = 7'h0F;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	retire_scoreboard board;

	// Chance in percent that the sender idles / the receiver stalls
	int idle_pct;
	int stall_pct;
	// Cycles the receiver still has to hold off; counted down by the receiver
	int hold_left;

	rv32i_instruction_execute_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Watchdog: a correct run finishes far earlier than this
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Result side: check the item taken at this edge, then pick the next stall.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall == 1'b0)
			board.check_result(out_data);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ---- instruction encoders ------------------------------------------------

	function automatic logic [31:0] enc_i(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
			logic [4:0] rs1, logic [11:0] imm);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
			logic [11:0] imm);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
			logic [12:0] off);
		return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] off);
		return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
	endfunction

	// ---- item drivers --------------------------------------------------------

	// Offer one item, idling first at random; valid stays high for the next item.
	task send_item(input in_item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		board.note_item(it);
	endtask

	task run_word(input logic [31:0] w);
		in_item_t it;
		it.mode        = MODE_EXEC;
		it.instruction = w;
		it.load_data   = $urandom;
		send_item(it);
	endtask

	task run_return(input logic [31:0] d);
		in_item_t it;
		it.mode        = MODE_LOAD;
		it.instruction = $urandom;
		it.load_data   = d;
		send_item(it);
	endtask

	// Drop valid and wait until every expected result item has been taken.
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_retires.size() != 0)
			@(posedge clk);
	endtask

	// One APB transfer: setup, then access; a read is checked against the copy.
	task cfg_access(input bit wr, input logic idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (wr)
			board.apply_config(idx, val);
		else if (prdata !== board.cfg_value[idx])
			board.report($sformatf("config read %0d got %h expected %h", idx, prdata,
				board.cfg_value[idx]));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task cfg_set(input logic idx, input logic [31:0] val);
		cfg_access(1'b1, idx, val);
		cfg_access(1'b0, idx, '0);
	endtask

	// ---- random stimulus -----------------------------------------------------

	// Mostly well-formed words with random content; registers drawn from a
	// small set so that dependencies and branch equality come up often.
	function automatic logic [31:0] make_word();
		logic [31:0] w;
		int          pick;
		w    = $urandom;
		pick = $urandom_range(99);
		if ($urandom_range(3) != 0) begin
			w[11:7]  = 5'($urandom_range(7));
			w[19:15] = 5'($urandom_range(7));
			w[24:20] = 5'($urandom_range(7));
		end
		if (pick < 8) begin
			w[6:0] = OP_LUI;
		end else if (pick < 13) begin
			w[6:0] = OP_JAL;
		end else if (pick < 18) begin
			w[6:0] = OP_JALR;
			if ($urandom_range(9) != 0)
				w[14:12] = F3_JALR;
		end else if (pick < 33) begin
			w[6:0] = OP_BRANCH;
		end else if (pick < 50) begin
			w[6:0] = OP_LOAD;
			if ($urandom_range(9) != 0) begin
				case ($urandom_range(4))
					0:       w[14:12] = F3_LB;
					1:       w[14:12] = F3_LH;
					2:       w[14:12] = F3_LW;
					3:       w[14:12] = F3_LBU;
					default: w[14:12] = F3_LHU;
				endcase
			end
		end else if (pick < 60) begin
			w[6:0] = OP_STORE;
			if ($urandom_range(9) != 0)
				w[14:12] = 3'($urandom_range(2));
		end else if (pick < 92) begin
			w[6:0] = OP_IMM;
			if (w[13:12] == 2'b01 && $urandom_range(9) != 0)
				w[31:25] = $urandom_range(1) ? F7_ALT : F7_ZERO;
		end else if (pick < 95) begin
			w[6:0] = OP_SYSTEM;
		end
		// keep halt for the very end of the run
		if (w == EBREAK_WORD)
			w[31] = 1'b1;
		return w;
	endfunction

	// Load returns mostly follow an open load; a few arrive with nothing pending.
	task random_run(input int count);
		logic [31:0] w;
		bit          load_open;
		load_open = 1'b0;
		repeat (count) begin
			if (load_open && $urandom_range(99) < 55) begin
				run_return($urandom);
				load_open = 1'b0;
			end else if ($urandom_range(99) < 3) begin
				run_return($urandom);
			end else begin
				w = make_word();
				run_word(w);
				if (w[6:0] == OP_LOAD)
					load_open = 1'b1;
			end
		end
	endtask

	// ---- main sequence -------------------------------------------------------

	initial begin
		board     = new();
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values read back
		cfg_access(1'b0, CFG_START_PC, '0);
		cfg_access(1'b0, CFG_STACK_TOP, '0);

		// Directed: immediate ALU, extremes of the 12-bit immediate, write to x0
		run_word(enc_i(OP_IMM, F3_ADD, 5'd1, 5'd0, 12'hFFF));
		run_word(enc_i(OP_IMM, F3_ADD, 5'd3, 5'd0, 12'h7FF));
		run_word({20'hFFFFF, 5'd4, OP_LUI});
		run_word(enc_i(OP_IMM, F3_ADD, 5'd0, 5'd1, 12'h005));
		run_word(enc_i(OP_IMM, F3_SLT, 5'd5, 5'd1, 12'h000));
		run_word(enc_i(OP_IMM, F3_SLTU, 5'd6, 5'd3, 12'hFFF));
		run_word(enc_i(OP_IMM, F3_XOR, 5'd7, 5'd3, 12'hFFF));
		run_word(enc_i(OP_IMM, F3_OR, 5'd8, 5'd4, 12'h555));
		run_word(enc_i(OP_IMM, F3_AND, 5'd9, 5'd1, 12'h7F0));
		run_word(enc_i(OP_IMM, F3_SLL, 5'd10, 5'd1, {F7_ZERO, 5'd31}));
		run_word(enc_i(OP_IMM, F3_SR, 5'd11, 5'd1, {F7_ZERO, 5'd31}));
		run_word(enc_i(OP_IMM, F3_SR, 5'd12, 5'd4, {F7_ALT, 5'd31}));
		// shift with a bad funct7
		run_word(enc_i(OP_IMM, F3_SR, 5'd13, 5'd4, {7'h01, 5'd1}));

		// Branches, taken and not, widest offsets, and an undefined funct3
		run_word(enc_b(F3_BEQ, 5'd0, 5'd0, 13'd8));
		run_word(enc_b(F3_BNE, 5'd1, 5'd0, 13'h1000));
		run_word(enc_b(F3_BLT, 5'd1, 5'd0, 13'h0FFE));
		run_word(enc_b(F3_BGE, 5'd3, 5'd1, 13'h1FFE));
		run_word(enc_b(F3_BLTU, 5'd0, 5'd1, 13'd12));
		run_word(enc_b(F3_BGEU, 5'd0, 5'd1, 13'd12));
		run_word(enc_b(3'd2, 5'd1, 5'd0, 13'd16));

		// Jumps: farthest forward JAL, JALR with a negative offset, JALR with bad funct3
		run_word(enc_j(5'd13, 21'h0FFFFE));
		run_word(enc_i(OP_JALR, F3_JALR, 5'd14, 5'd1, 12'hFFF));
		run_word(enc_i(OP_JALR, 3'd1, 5'd14, 5'd1, 12'h004));

		// Loads of every size with returns that exercise the extension
		run_word(enc_i(OP_LOAD, F3_LB, 5'd15, SP_INDEX, 12'h000));
		run_return(32'h0000_0080);
		run_word(enc_i(OP_LOAD, F3_LH, 5'd16, SP_INDEX, 12'h800));
		run_return(32'hFFFF_8000);
		run_word(enc_i(OP_LOAD, F3_LW, 5'd17, 5'd3, 12'h7FF));
		run_return(32'h8000_0001);
		run_word(enc_i(OP_LOAD, F3_LBU, 5'd18, SP_INDEX, 12'h001));
		run_return(32'hFFFF_FFFF);
		run_word(enc_i(OP_LOAD, F3_LHU, 5'd19, SP_INDEX, 12'h002));
		run_return(32'hFFFF_FFFF);
		// load to x0 returns without a write; a stray return changes nothing
		run_word(enc_i(OP_LOAD, F3_LW, 5'd0, SP_INDEX, 12'h004));
		run_return(32'h1234_5678);
		run_return(32'hDEAD_BEEF);
		// a load survives other work and is replaced by the next load
		run_word(enc_i(OP_LOAD, F3_LB, 5'd20, SP_INDEX, 12'h000));
		run_word(enc_i(OP_IMM, F3_ADD, 5'd21, 5'd20, 12'h001));
		run_word(enc_i(OP_LOAD, F3_LH, 5'd22, SP_INDEX, 12'h010));
		run_return(32'h0000_8080);
		run_word(enc_i(OP_LOAD, 3'd3, 5'd23, SP_INDEX, 12'h000));

		// Stores, and an undefined store size
		run_word(enc_s(F3_SB, SP_INDEX, 5'd1, 12'h800));
		run_word(enc_s(F3_SH, 5'd0, 5'd4, 12'h000));
		run_word(enc_s(F3_SW, 5'd3, 5'd1, 12'h7FF));
		run_word(enc_s(3'd3, 5'd3, 5'd1, 12'h000));

		// Outside the handled set: R-type, AUIPC, FENCE, ECALL, near-EBREAK
		run_word({F7_ZERO, 5'd2, 5'd1, F3_ADD, 5'd3, OP_RTYPE});
		run_word({20'h12345, 5'd5, OP_AUIPC});
		run_word({25'd0, OP_FENCE});
		run_word({25'd0, OP_SYSTEM});
		run_word(EBREAK_WORD ^ 32'h0030_0000);
		drain();

		// Phase: no idling; PC at zero, stack at the top of memory
		cfg_set(CFG_START_PC, '0);
		cfg_set(CFG_STACK_TOP, '1);
		idle_pct  = 0;
		stall_pct = 0;
		random_run(90);
		// long hold-off while the sender keeps pushing, so the core backs up
		hold_left = 400;
		random_run(40);
		random_run(80);
		drain();

		// Phase: sender idles often, with a full pause in the middle
		cfg_set(CFG_START_PC, '1);
		cfg_set(CFG_STACK_TOP, '0);
		idle_pct = 69;
		random_run(90);
		drain();
		random_run(85);
		drain();

		// Phase: receiver stalls often
		cfg_set(CFG_START_PC, $urandom);
		cfg_set(CFG_STACK_TOP, $urandom);
		idle_pct  = 0;
		stall_pct = 69;
		random_run(170);
		drain();

		// Phase: light idling on both sides, then halt
		cfg_set(CFG_START_PC, $urandom);
		cfg_set(CFG_STACK_TOP, $urandom);
		idle_pct  = 9;
		stall_pct = 9;
		random_run(170);
		run_word(EBREAK_WORD);
		// after halt every item is ignored
		run_word(enc_i(OP_IMM, F3_ADD, 5'd1, 5'd0, 12'h001));
		run_return(32'hFFFF_FFFF);
		run_word(enc_i(OP_LOAD, F3_LW, 5'd2, 5'd0, 12'h000));
		drain();

		// let any stray result item show up before the verdict
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.expected_retires.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
